// ===== rtl/lrb_pkg.sv =====
// Shared constants, types and ring helpers for the overwriting log ring buffer.
`default_nettype none

package lrb_pkg;

    // Ring size; a power of two so a cursor wraps by dropping high bits.
    localparam int DEPTH      = 1024 * 4;
    localparam int MAX_BURST  = 64;
    localparam int PW         = $clog2(DEPTH);
    localparam int DATA_W     = 8;
    localparam int CURSOR_W   = 12;
    localparam int LIM_W      = 7;
    localparam int OUT_POS_W  = 12;
    localparam int CMP_W      = (PW + 1 > LIM_W) ? PW + 1 : LIM_W;

    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef logic [PW-1:0] pos_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic                 byte_valid;
        logic [OUT_POS_W-1:0] next_cursor;
        logic [OUT_POS_W-1:0] fill_level;
        logic                 last;
    } rsp_meta_t;

    typedef struct packed {
        logic [DATA_W-1:0]    out_byte;
        logic                 byte_valid;
        logic [OUT_POS_W-1:0] next_cursor;
        logic [OUT_POS_W-1:0] fill_level;
        logic                 last;
    } out_item_t;

    function automatic pos_t ring_next(input pos_t p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + pos_t'(1);
    endfunction

    // Distance from 'from' forward to 'to' around the ring.
    function automatic logic [PW:0] ring_dist(input pos_t from, input pos_t to);
        logic [PW:0] f;
        logic [PW:0] t;
        f = {1'b0, from};
        t = {1'b0, to};
        return (t >= f) ? (t - f) : ((PW + 1)'(DEPTH) - (f - t));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lrb_ram.sv =====
// Single-port synchronous RAM with registered read data.
`default_nettype none

module lrb_ram #(
    parameter int WIDTH   = 8,
    parameter int ENTRIES = 4096,
    parameter int AWIDTH  = $clog2(ENTRIES)
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [AWIDTH-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lrb_out_fifo.sv =====
// Small result queue between the RAM response stage and the output port.
`default_nettype none

module lrb_out_fifo (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    input  wire lrb_pkg::out_item_t              push_item,
    input  wire logic                            pop,
    output logic                                 head_valid,
    output lrb_pkg::out_item_t                   head_item,
    output logic [lrb_pkg::FIFO_CNT_W-1:0]       count
);
    import lrb_pkg::*;

    out_item_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   cnt_reg, cnt_next;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_valid = (cnt_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign count      = cnt_reg;

endmodule

`default_nettype wire

// ===== rtl/overwriting_log_ring_buffer_core.sv =====
// Top level: overwriting byte log ring with RAM store, read sequencer and result queue.
`default_nettype none

// Channel | handshake            | payload
// --------+----------------------+-----------------------------------------------
// in      | in_valid / in_stall  | opcode, data_byte, from_oldest, read_cursor,
//         |                      | read_limit
// out     | out_valid / out_stall| out_byte, byte_valid, next_cursor, fill_level,
//         |                      | last
//
// Append: written in the accept cycle. Read: in_stall stays high while the sequencer
// issues one RAM read per returned byte through the single RAM port; results leave one
// per cycle while out_stall is low. After reset the store is swept to zero, one entry a
// cycle, with in_stall high. Results pass a registered RAM stage and a 3-entry queue;
// the sequencer only issues a read when the queue has a slot for it, so out_stall never
// reaches the RAM path. An append may follow a read while its results drain.

module overwriting_log_ring_buffer_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              opcode,
    input  wire logic [lrb_pkg::DATA_W-1:0]        data_byte,
    input  wire logic                              from_oldest,
    input  wire logic [lrb_pkg::CURSOR_W-1:0]      read_cursor,
    input  wire logic [lrb_pkg::LIM_W-1:0]         read_limit,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [lrb_pkg::DATA_W-1:0]        out_byte,
    output logic                                   byte_valid,
    output logic      [lrb_pkg::OUT_POS_W-1:0]     next_cursor,
    output logic      [lrb_pkg::OUT_POS_W-1:0]     fill_level,
    output logic                                   last
);
    import lrb_pkg::*;

    state_t               state_reg, state_next;

    pos_t                 oldest_reg, oldest_next;
    pos_t                 wpos_reg, wpos_next;
    pos_t                 clr_addr_reg, clr_addr_next;

    // Read sequencer
    pos_t                 rd_pos_reg, rd_pos_next;
    logic [LIM_W-1:0]     rd_left_reg, rd_left_next;
    logic                 rd_empty_reg, rd_empty_next;
    logic [OUT_POS_W-1:0] rd_fill_reg, rd_fill_next;

    // RAM response stage
    logic                 rsp_valid_reg;
    rsp_meta_t            rsp_meta_reg, rsp_meta_next;

    logic                 in_accept;
    logic                 issue_ok;
    logic                 issue;

    logic                 ram_en, ram_we;
    pos_t                 ram_addr;
    logic [DATA_W-1:0]    ram_wdata, ram_q;

    logic [LIM_W-1:0]     lim_sat;
    pos_t                 start_pos;
    logic [PW:0]          fill_dist;
    logic [CMP_W-1:0]     avail_w, lim_w, count_w;

    out_item_t            push_item;
    out_item_t            head_item;
    logic [FIFO_CNT_W-1:0] fifo_cnt;
    logic                 out_pop;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Slot check counts the result still in the RAM stage.
    assign issue_ok = ((FIFO_CNT_W + 1)'(fifo_cnt) + (FIFO_CNT_W + 1)'(rsp_valid_reg))
                      < (FIFO_CNT_W + 1)'(FIFO_DEPTH);

    // Read setup, evaluated on the accept cycle
    always_comb
    begin
        lim_sat   = (read_limit > LIM_W'(MAX_BURST)) ? LIM_W'(MAX_BURST) : read_limit;
        start_pos = from_oldest ? oldest_reg : PW'(read_cursor);
        fill_dist = ring_dist(oldest_reg, wpos_reg);
        avail_w   = CMP_W'(ring_dist(start_pos, wpos_reg));
        lim_w     = CMP_W'(lim_sat);
        count_w   = (avail_w < lim_w) ? avail_w : lim_w;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == PW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept && opcode == OP_READ)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (issue_ok && (rd_empty_reg || rd_left_reg == LIM_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // RAM control and datapath
    always_comb
    begin
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = wpos_reg;
        ram_wdata     = data_byte;
        issue         = 1'b0;
        oldest_next   = oldest_reg;
        wpos_next     = wpos_reg;
        clr_addr_next = clr_addr_reg;
        rd_pos_next   = rd_pos_reg;
        rd_left_next  = rd_left_reg;
        rd_empty_next = rd_empty_reg;
        rd_fill_next  = rd_fill_reg;
        rsp_meta_next = rsp_meta_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_addr      = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + pos_t'(1);
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (opcode == OP_APPEND)
                    begin
                        ram_we    = 1'b1;
                        wpos_next = ring_next(wpos_reg);
                        // ring full: drop the oldest byte
                        if (ring_next(wpos_reg) == oldest_reg)
                        begin
                            oldest_next = ring_next(oldest_reg);
                        end
                    end
                    else
                    begin
                        rd_pos_next   = start_pos;
                        rd_left_next  = LIM_W'(count_w);
                        rd_empty_next = (count_w == '0);
                        rd_fill_next  = OUT_POS_W'(fill_dist);
                    end
                end
            end
            ST_READ:
            begin
                if (issue_ok)
                begin
                    issue = 1'b1;
                    if (rd_empty_reg)
                    begin
                        rsp_meta_next.byte_valid  = 1'b0;
                        rsp_meta_next.next_cursor = OUT_POS_W'(rd_pos_reg);
                        rsp_meta_next.fill_level  = rd_fill_reg;
                        rsp_meta_next.last        = 1'b1;
                    end
                    else
                    begin
                        ram_en                    = 1'b1;
                        ram_addr                  = rd_pos_reg;
                        rsp_meta_next.byte_valid  = 1'b1;
                        rsp_meta_next.next_cursor = OUT_POS_W'(ring_next(rd_pos_reg));
                        rsp_meta_next.fill_level  = rd_fill_reg;
                        rsp_meta_next.last        = (rd_left_reg == LIM_W'(1));
                        rd_pos_next               = ring_next(rd_pos_reg);
                        rd_left_next              = rd_left_reg - LIM_W'(1);
                    end
                end
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            oldest_reg    <= '0;
            wpos_reg      <= '0;
            clr_addr_reg  <= '0;
            rd_left_reg   <= '0;
            rd_empty_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            wpos_reg      <= wpos_next;
            clr_addr_reg  <= clr_addr_next;
            rd_left_reg   <= rd_left_next;
            rd_empty_reg  <= rd_empty_next;
            rsp_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg   <= rd_pos_next;
        rd_fill_reg  <= rd_fill_next;
        rsp_meta_reg <= rsp_meta_next;
    end

    lrb_ram #(
        .WIDTH   (DATA_W),
        .ENTRIES (DEPTH),
        .AWIDTH  (PW)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_q)
    );

    // Empty results carry a zero byte; RAM data is only meaningful for real bytes.
    always_comb
    begin
        push_item.out_byte    = rsp_meta_reg.byte_valid ? ram_q : '0;
        push_item.byte_valid  = rsp_meta_reg.byte_valid;
        push_item.next_cursor = rsp_meta_reg.next_cursor;
        push_item.fill_level  = rsp_meta_reg.fill_level;
        push_item.last        = rsp_meta_reg.last;
    end

    assign out_pop = out_valid && !out_stall;

    lrb_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (rsp_valid_reg),
        .push_item  (push_item),
        .pop        (out_pop),
        .head_valid (out_valid),
        .head_item  (head_item),
        .count      (fifo_cnt)
    );

    assign out_byte    = head_item.out_byte;
    assign byte_valid  = head_item.byte_valid;
    assign next_cursor = head_item.next_cursor;
    assign fill_level  = head_item.fill_level;
    assign last        = head_item.last;

endmodule

`default_nettype wire

// ===== dv/overwriting_log_ring_buffer_core_tb.sv =====
// Self-checking testbench for the overwriting log ring buffer core: appends, reads, wrap.
module overwriting_log_ring_buffer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrb_pkg::*;

    // Bound for the slowest legal run (store clear, ~240 transfers with the longest
    // gaps, reads of 64 results each with the longest stall per result), with a wide
    // margin.
    localparam int unsigned TIMEOUT_CYCLES = 2_000_000;
    // Quiet time after the last expected result: a read holds the sequencer for each
    // result it issues, then the RAM stage and the 3-deep result queue.
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 220;

    // One input transfer as the generator queues it.
    typedef struct {
        logic                opcode;
        logic [DATA_W-1:0]   data;
        logic                from_oldest;
        logic [CURSOR_W-1:0] cursor;
        logic [LIM_W-1:0]    limit;
    } log_cmd_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 opcode = OP_APPEND;
    logic [DATA_W-1:0]    data_byte = '0;
    logic                 from_oldest = 1'b0;
    logic [CURSOR_W-1:0]  read_cursor = '0;
    logic [LIM_W-1:0]     read_limit = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [DATA_W-1:0]    out_byte;
    logic                 byte_valid;
    logic [OUT_POS_W-1:0] next_cursor;
    logic [OUT_POS_W-1:0] fill_level;
    logic                 last;

    overwriting_log_ring_buffer_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .data_byte   (data_byte),
        .from_oldest (from_oldest),
        .read_cursor (read_cursor),
        .read_limit  (read_limit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .next_cursor (next_cursor),
        .fill_level  (fill_level),
        .last        (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the ring, updated in transfer order on the input side
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] shadow_log [DEPTH];
    pos_t              shadow_oldest = '0;
    pos_t              shadow_write = '0;

    log_cmd_t   pending_cmds[$];     // generated, not yet driven
    out_item_t  pending_results[$];  // predicted, not yet seen on the output

    int unsigned cycle_cnt = 0;
    int          cmds_total = 0;
    int          cmds_accepted = 0;
    int          appends_seen = 0;
    int          reads_seen = 0;
    int          empty_reads = 0;
    int          results_checked = 0;
    int          mismatch_count = 0;
    int          gen_appends = 0;    // generator-side append count, tracks the tail
    bit          ring_wrapped = 1'b0;

    // Gap length for either side. In one window of every four (cycle_cnt[9:8] zero) both
    // sides run flat out; otherwise mostly back-to-back, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (cycle_cnt[9:8] == 2'b00)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic queue_cmd(input logic op, input logic [DATA_W-1:0] d, input logic fo,
                             input logic [CURSOR_W-1:0] cur, input logic [LIM_W-1:0] lim);
        log_cmd_t c;
        c.opcode      = op;
        c.data        = d;
        c.from_oldest = fo;
        c.cursor      = cur;
        c.limit       = lim;
        pending_cmds.push_back(c);
        cmds_total++;
        if (op == OP_APPEND)
            gen_appends++;
    endtask

    // Works out the results one accepted transfer causes and advances the shadow ring.
    task automatic predict_log_access(input log_cmd_t c);
        pos_t        start;
        pos_t        p;
        pos_t        fill;
        int unsigned avail;
        int unsigned lim;
        int unsigned count;
        out_item_t   r;
        if (c.opcode == OP_APPEND)
        begin
            shadow_log[shadow_write] = c.data;
            shadow_write = shadow_write + pos_t'(1);
            // tail caught the head: drop the oldest byte
            if (shadow_write == shadow_oldest)
            begin
                shadow_oldest = shadow_oldest + pos_t'(1);
                ring_wrapped  = 1'b1;
            end
            appends_seen++;
            return;
        end
        reads_seen++;
        lim   = (c.limit > MAX_BURST) ? MAX_BURST : c.limit;
        start = c.from_oldest ? shadow_oldest : pos_t'(c.cursor);
        // ring is a power of two, so the pos_t subtraction is the ring distance
        fill  = shadow_write - shadow_oldest;
        avail = (start == shadow_write) ? 0 : int'(pos_t'(shadow_write - start));
        count = (avail < lim) ? avail : lim;
        r.fill_level = OUT_POS_W'(fill);
        if (count == 0)
        begin
            // nothing new, or a zero limit: one empty result at the start position
            r.out_byte    = '0;
            r.byte_valid  = 1'b0;
            r.next_cursor = OUT_POS_W'(start);
            r.last        = 1'b1;
            pending_results.push_back(r);
            empty_reads++;
            return;
        end
        p = start;
        for (int k = 0; k < count; k++)
        begin
            r.out_byte    = shadow_log[p];
            p             = p + pos_t'(1);
            r.byte_valid  = 1'b1;
            r.next_cursor = OUT_POS_W'(p);
            r.last        = (k + 1 == count);
            pending_results.push_back(r);
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one transfer per accepted slot, random gaps between them
    // ------------------------------------------------------------------
    log_cmd_t driven_cmd;
    int       send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_log_access(driven_cmd);
                cmds_accepted++;
            end
            // payload may only change once the current transfer is gone
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    driven_cmd   = pending_cmds.pop_front();
                    in_valid    <= 1'b1;
                    opcode      <= driven_cmd.opcode;
                    data_byte   <= driven_cmd.data;
                    from_oldest <= driven_cmd.from_oldest;
                    read_cursor <= driven_cmd.cursor;
                    read_limit  <= driven_cmd.limit;
                    send_gap    <= pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each transfer against the oldest prediction
    // ------------------------------------------------------------------
    int recv_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing expected: out_byte 0x%0h next_cursor 0x%0h",
                           out_byte, next_cursor);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("out_byte", 16'(want.out_byte), 16'(out_byte));
                    check_field("byte_valid", 16'(want.byte_valid), 16'(byte_valid));
                    check_field("next_cursor", 16'(want.next_cursor), 16'(next_cursor));
                    check_field("fill_level", 16'(want.fill_level), 16'(fill_level));
                    check_field("last", 16'(want.last), 16'(last));
                    results_checked++;
                end
            end
            // stall stretches start only from a non-stalled cycle
            if (recv_gap != 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                recv_gap  <= pick_gap();
            end
        end
    end

    // Watchdog; also counts cycles for the quiet windows.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == TIMEOUT_CYCLES)
        begin
            $error("timeout: %0d of %0d transfers accepted, %0d results outstanding",
                   cmds_accepted, cmds_total, pending_results.size());
            $display("overwriting_log_ring_buffer_core_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        pos_t        gen_write;
        pos_t        gen_oldest;
        logic [CURSOR_W-1:0] cur;
        logic [LIM_W-1:0]    lim;
        int          pick;
        for (int i = 0; i < DEPTH; i++)
            shadow_log[i] = '0;

        // Directed: empty ring, a few bytes, then the read corner cases.
        queue_cmd(OP_READ, 8'h00, 1'b1, 12'hABC, 7'd1);      // empty, from oldest
        queue_cmd(OP_READ, 8'h00, 1'b0, 12'h000, 7'd64);     // empty at the tail
        queue_cmd(OP_READ, 8'hFF, 1'b0, 12'hFFF, 7'd127);    // stale cursor, one cleared byte
        queue_cmd(OP_APPEND, 8'h00, 1'b0, 12'h000, 7'd0);
        queue_cmd(OP_APPEND, 8'hFF, 1'b0, 12'h000, 7'd0);
        queue_cmd(OP_APPEND, 8'hA5, 1'b0, 12'h000, 7'd0);
        queue_cmd(OP_APPEND, 8'h5A, 1'b0, 12'h000, 7'd0);
        queue_cmd(OP_APPEND, 8'h3C, 1'b1, 12'hFFF, 7'h7F);   // read fields ignored
        queue_cmd(OP_READ, 8'h00, 1'b1, 12'h000, 7'd64);     // everything stored
        queue_cmd(OP_READ, 8'h00, 1'b1, 12'h000, 7'd2);      // limit cuts it short
        queue_cmd(OP_READ, 8'h00, 1'b0, 12'h002, 7'd127);    // oversized limit
        queue_cmd(OP_READ, 8'h00, 1'b0, 12'h001, 7'd0);      // zero limit
        queue_cmd(OP_READ, 8'h00, 1'b0, 12'h005, 7'd10);     // cursor at the tail
        queue_cmd(OP_READ, 8'h00, 1'b0, 12'hFFF, 7'd3);      // wraps through zero
        queue_cmd(OP_READ, 8'h00, 1'b0, 12'h800, 7'd65);     // far stale, saturated
        queue_cmd(OP_READ, 8'h00, 1'b1, 12'h800, 7'd64);     // cursor ignored
        queue_cmd(OP_READ, 8'h00, 1'b0, 12'h000, 7'd1);

        // Random mix of appends and reads around the tail and the head.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            gen_write  = pos_t'(gen_appends);
            gen_oldest = (gen_appends >= DEPTH) ? pos_t'(gen_appends - (DEPTH - 1)) : '0;
            if ($urandom_range(0, 99) < 35)
            begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0: cur = CURSOR_W'($urandom);
                    1: cur = CURSOR_W'(gen_write - pos_t'($urandom_range(0, 70)));
                    2: cur = CURSOR_W'($urandom_range(0, DEPTH - 1));
                    default: cur = CURSOR_W'(gen_oldest + pos_t'($urandom_range(0, 20)));
                endcase
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    lim = '0;
                else if (pick < 3)
                    lim = LIM_W'($urandom_range(MAX_BURST + 1, 127));
                else
                    lim = LIM_W'($urandom_range(1, MAX_BURST));
                queue_cmd(OP_READ, DATA_W'($urandom), (pick == 0) ? 1'b0 : 1'($urandom),
                          cur, lim);
            end
            else
            begin
                queue_cmd(OP_APPEND, DATA_W'($urandom_range(0, 255)), 1'($urandom),
                          CURSOR_W'($urandom), LIM_W'($urandom));
            end
        end

        // Single reset at start; the block then clears its store with in_stall high.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (cmds_accepted != cmds_total)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("coverage: %0d appends (ring overrun: %s), %0d reads, %0d of them empty",
                 appends_seen, ring_wrapped ? "yes" : "no", reads_seen, empty_reads);
        $display("checked %0d result transfers, %0d mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("overwriting_log_ring_buffer_core_tb: done, clean");
        else
            $display("overwriting_log_ring_buffer_core_tb: done, errors");
        $finish;
    end

endmodule
